### hw/rtl/ffdl_pkg.sv
// shared constants, types and helper functions of the fractional feedback delay line
// no dependencies; every other file takes names from here by scope
`timescale 1ns / 1ps
`default_nettype none

package ffdl_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int STORE_DEPTH    = 131072;
    localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
    localparam int DELAY_BITS     = 17;
    localparam int COEF_BITS      = 16;
    localparam int CFG_DATA_BITS  = 17;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PROD_BITS      = SAMPLE_BITS + 3;
    localparam int MUL_CNT_BITS   = $clog2(COEF_BITS + 1);
    localparam int DMOD_CNT_BITS  = $clog2(DELAY_BITS + 1);
    localparam int FRAC_SHIFT     = 16;
    localparam int GAIN_SHIFT     = 15;

    localparam logic [ADDR_BITS:0]   DEPTH_WIDE = (ADDR_BITS + 1)'(STORE_DEPTH);
    localparam logic [ADDR_BITS-1:0] LAST_ADDR  = ADDR_BITS'(STORE_DEPTH - 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_WHOLE    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_FRACTION = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN  = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIX_LEVEL      = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_BYPASS         = CFG_INDEX_BITS'(4);
    localparam logic [CFG_INDEX_BITS-1:0] REG_USE_EXT_FB     = CFG_INDEX_BITS'(5);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_Y_GO,
        ST_Y_WAIT,
        ST_FB_GO,
        ST_FB_WAIT,
        ST_WRITE,
        ST_MIX_WAIT,
        ST_RD_TAP,
        ST_TAP_GO,
        ST_TAP_WAIT,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic b_signed;
        logic shift16;
    } smul_req_t;

    // clamp to the signed sample range
    function automatic sample_t sat_sample(input logic signed [PROD_BITS:0] v);
        logic pos_ovf;
        logic neg_ovf;
        pos_ovf = !v[PROD_BITS] && (|v[PROD_BITS-1:SAMPLE_BITS-1]);
        neg_ovf = v[PROD_BITS] && !(&v[PROD_BITS-1:SAMPLE_BITS-1]);
        if (pos_ovf)
        begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else if (neg_ovf)
        begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            return v[SAMPLE_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ffdl_if.sv
// valid/ready channel interfaces for the input item and the result item
// depends on ffdl_pkg for the sample width
`timescale 1ns / 1ps
`default_nettype none

interface ffdl_in_if;
    logic                               valid;
    logic                               ready;
    logic [ffdl_pkg::SAMPLE_BITS-1:0]   sample_in;
    logic [ffdl_pkg::SAMPLE_BITS-1:0]   external_feedback;

    modport source (output valid, output sample_in, output external_feedback, input ready);
    modport sink   (input valid, input sample_in, input external_feedback, output ready);
endinterface

interface ffdl_out_if;
    logic                               valid;
    logic                               ready;
    logic [ffdl_pkg::SAMPLE_BITS-1:0]   sample_out;
    logic [ffdl_pkg::SAMPLE_BITS-1:0]   feedback_out;

    modport source (output valid, output sample_out, output feedback_out, input ready);
    modport sink   (input valid, input sample_out, input feedback_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/ffdl_store.sv
// circular sample store: one write port, one read port with registered read data
// depends on ffdl_pkg for depth and sample width
`timescale 1ns / 1ps
`default_nettype none

module ffdl_store (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [ffdl_pkg::ADDR_BITS-1:0]     waddr,
    input  wire logic [ffdl_pkg::SAMPLE_BITS-1:0]   wdata,
    input  wire logic [ffdl_pkg::ADDR_BITS-1:0]     raddr,
    output      logic [ffdl_pkg::SAMPLE_BITS-1:0]   rdata
);

    logic [ffdl_pkg::SAMPLE_BITS-1:0] mem [ffdl_pkg::STORE_DEPTH];
    logic [ffdl_pkg::SAMPLE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/ffdl_dmod.sv
// reduces the whole delay modulo the store depth, one delay bit per cycle
// restoring remainder; depends on ffdl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ffdl_dmod (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [ffdl_pkg::DELAY_BITS-1:0]    delay,
    output      logic                               busy,
    output      logic [ffdl_pkg::ADDR_BITS-1:0]     rem
);

    logic                                   busy_reg;
    logic                                   busy_next;
    logic [ffdl_pkg::DMOD_CNT_BITS-1:0]     cnt_reg;
    logic [ffdl_pkg::DMOD_CNT_BITS-1:0]     cnt_next;
    logic [ffdl_pkg::DELAY_BITS-1:0]        sh_reg;
    logic [ffdl_pkg::DELAY_BITS-1:0]        sh_next;
    logic [ffdl_pkg::ADDR_BITS-1:0]         rem_reg;
    logic [ffdl_pkg::ADDR_BITS-1:0]         rem_next;
    logic [ffdl_pkg::ADDR_BITS:0]           trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        // shift in the next delay bit, subtract the depth when it fits
        trial     = {rem_reg, sh_reg[ffdl_pkg::DELAY_BITS-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ffdl_pkg::DMOD_CNT_BITS'(ffdl_pkg::DELAY_BITS);
            sh_next   = delay;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= ffdl_pkg::DEPTH_WIDE)
            begin
                rem_next = ffdl_pkg::ADDR_BITS'(trial - ffdl_pkg::DEPTH_WIDE);
            end
            else
            begin
                rem_next = trial[ffdl_pkg::ADDR_BITS-1:0];
            end
            sh_next  = {sh_reg[ffdl_pkg::DELAY_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ffdl_pkg::DMOD_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            sh_reg   <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            sh_reg   <= sh_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

### hw/rtl/ffdl_smul.sv
// shared serial multiplier: one coefficient bit per cycle, then a rounding step
// product of a signed operand one bit wider than a sample and a 16-bit coefficient; depends on ffdl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ffdl_smul (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ffdl_pkg::smul_req_t                req,
    input  wire logic signed [ffdl_pkg::SAMPLE_BITS:0] a_op,
    input  wire logic [ffdl_pkg::COEF_BITS-1:0]     b_op,
    output      logic                               done,
    output      ffdl_pkg::prod_t                    res
);

    localparam int WIDE_BITS = ffdl_pkg::PROD_BITS + ffdl_pkg::COEF_BITS;

    logic                                       busy_reg;
    logic                                       busy_next;
    logic                                       done_reg;
    logic                                       done_next;
    logic [ffdl_pkg::MUL_CNT_BITS-1:0]          cnt_reg;
    logic [ffdl_pkg::MUL_CNT_BITS-1:0]          cnt_next;
    logic signed [ffdl_pkg::SAMPLE_BITS:0]      a_reg;
    logic signed [ffdl_pkg::SAMPLE_BITS:0]      a_next;
    ffdl_pkg::prod_t                            p_reg;
    ffdl_pkg::prod_t                            p_next;
    logic [ffdl_pkg::COEF_BITS-1:0]             q_reg;
    logic [ffdl_pkg::COEF_BITS-1:0]             q_next;
    logic                                       bsig_reg;
    logic                                       bsig_next;
    logic                                       sh16_reg;
    logic                                       sh16_next;
    ffdl_pkg::prod_t                            res_reg;
    ffdl_pkg::prod_t                            res_next;
    ffdl_pkg::prod_t                            a_ext;
    ffdl_pkg::prod_t                            addend;
    ffdl_pkg::prod_t                            sum;
    logic [WIDE_BITS-1:0]                       rnd_add;
    logic [WIDE_BITS-1:0]                       rsum;

    always_comb
    begin
        a_ext = {{(ffdl_pkg::PROD_BITS-ffdl_pkg::SAMPLE_BITS-1){a_reg[ffdl_pkg::SAMPLE_BITS]}},
                 a_reg};
        // the top bit of a signed coefficient weighs negative
        if (!q_reg[0])
        begin
            addend = '0;
        end
        else if (bsig_reg && (cnt_reg == ffdl_pkg::MUL_CNT_BITS'(1)))
        begin
            addend = -a_ext;
        end
        else
        begin
            addend = a_ext;
        end
        sum = p_reg + addend;

        if (sh16_reg)
        begin
            rnd_add = WIDE_BITS'(1) << (ffdl_pkg::FRAC_SHIFT - 1);
        end
        else
        begin
            rnd_add = WIDE_BITS'(1) << (ffdl_pkg::GAIN_SHIFT - 1);
        end
        rsum = {p_reg, q_reg} + rnd_add;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        p_next    = p_reg;
        q_next    = q_reg;
        bsig_next = bsig_reg;
        sh16_next = sh16_reg;
        res_next  = res_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ffdl_pkg::MUL_CNT_BITS'(ffdl_pkg::COEF_BITS);
            a_next    = a_op;
            p_next    = '0;
            q_next    = b_op;
            bsig_next = req.b_signed;
            sh16_next = req.shift16;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            p_next   = sum >>> 1;
            q_next   = {sum[0], q_reg[ffdl_pkg::COEF_BITS-1:1]};
            cnt_next = cnt_reg - 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh16_reg)
            begin
                res_next = rsum[ffdl_pkg::PROD_BITS+ffdl_pkg::FRAC_SHIFT-1:ffdl_pkg::FRAC_SHIFT];
            end
            else
            begin
                res_next = rsum[ffdl_pkg::PROD_BITS+ffdl_pkg::GAIN_SHIFT-1:ffdl_pkg::GAIN_SHIFT];
            end
            done_next = 1'b1;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        bsig_reg <= bsig_next;
        sh16_reg <= sh16_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

### hw/rtl/fractional_feedback_delay_line.sv
// with interpolation and internal feedback an item takes four multiplies on the shared serial
// multiplier, two reads, the tap read and the load. zero whole delay skips the reads and the
// interpolation, external feedback the feedback multiply; bypass goes straight to the tap read.
// one item at a time; input reopens only after the load, while the result waits to be taken.
// a write of delay_whole holds off items while it is reduced mod depth.
// reset clears pointer, state and config registers; unwritten store entries read as zero (no clearing pass).
`timescale 1ns / 1ps
`default_nettype none

module fractional_feedback_delay_line (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    ffdl_in_if.sink                                     sample_ch,
    ffdl_out_if.source                                  result_ch,
    input  wire logic                                   cfg_we,
    input  wire logic [ffdl_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [ffdl_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int SB = ffdl_pkg::SAMPLE_BITS;
    localparam int AB = ffdl_pkg::ADDR_BITS;
    localparam int PB = ffdl_pkg::PROD_BITS;

    ffdl_pkg::seq_state_t               state_reg;
    ffdl_pkg::seq_state_t               state_next;

    logic [ffdl_pkg::DELAY_BITS-1:0]    delay_whole_reg;
    logic [ffdl_pkg::COEF_BITS-1:0]     delay_fraction_reg;
    logic [ffdl_pkg::COEF_BITS-1:0]     feedback_gain_reg;
    logic [ffdl_pkg::COEF_BITS-1:0]     mix_level_reg;
    logic                               bypass_reg;
    logic                               use_ext_fb_reg;

    logic [AB-1:0]                      wp_reg;
    logic                               wrapped_reg;
    logic                               rd_ok_reg;

    ffdl_pkg::sample_t                  x_reg;
    ffdl_pkg::sample_t                  ext_reg;
    ffdl_pkg::sample_t                  a_reg;
    ffdl_pkg::sample_t                  y_reg;
    ffdl_pkg::sample_t                  stored_reg;
    ffdl_pkg::sample_t                  mixed_reg;
    ffdl_pkg::sample_t                  tap_reg;

    logic                               out_valid_reg;
    ffdl_pkg::sample_t                  out_sample_reg;
    ffdl_pkg::sample_t                  out_fb_reg;

    logic                               in_fire;
    logic                               out_free;
    logic                               dmod_busy;
    logic [AB-1:0]                      dmod_rem;
    logic [AB:0]                        wrap_sum;
    logic [AB-1:0]                      rd_idx;
    logic [AB-1:0]                      rd_prev;
    logic [AB-1:0]                      raddr;
    logic                               store_we;
    logic [SB-1:0]                      rdata;
    ffdl_pkg::sample_t                  rd_val;

    ffdl_pkg::smul_req_t                mul_req;
    logic signed [SB:0]                 mul_a;
    logic [ffdl_pkg::COEF_BITS-1:0]     mul_b;
    logic                               mul_done;
    ffdl_pkg::prod_t                    mul_res;

    logic signed [PB:0]                 x_wide;
    logic signed [PB:0]                 ext_wide;
    logic signed [PB:0]                 res_wide;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_whole_reg    <= '0;
            delay_fraction_reg <= '0;
            feedback_gain_reg  <= '0;
            mix_level_reg      <= '0;
            bypass_reg         <= 1'b0;
            use_ext_fb_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ffdl_pkg::REG_DELAY_WHOLE:
                    delay_whole_reg <= cfg_data[ffdl_pkg::DELAY_BITS-1:0];
                ffdl_pkg::REG_DELAY_FRACTION:
                    delay_fraction_reg <= cfg_data[ffdl_pkg::COEF_BITS-1:0];
                ffdl_pkg::REG_FEEDBACK_GAIN:
                    feedback_gain_reg <= cfg_data[ffdl_pkg::COEF_BITS-1:0];
                ffdl_pkg::REG_MIX_LEVEL:
                    mix_level_reg <= cfg_data[ffdl_pkg::COEF_BITS-1:0];
                ffdl_pkg::REG_BYPASS:
                    bypass_reg <= cfg_data[0];
                ffdl_pkg::REG_USE_EXT_FB:
                    use_ext_fb_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    ffdl_dmod u_dmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_we && (cfg_index == ffdl_pkg::REG_DELAY_WHOLE)),
        .delay (cfg_data[ffdl_pkg::DELAY_BITS-1:0]),
        .busy  (dmod_busy),
        .rem   (dmod_rem)
    );

    // ---------------- read addressing ----------------
    always_comb
    begin
        wrap_sum = {1'b0, wp_reg} + ffdl_pkg::DEPTH_WIDE - {1'b0, dmod_rem};
        if (wp_reg >= dmod_rem)
        begin
            rd_idx = wp_reg - dmod_rem;
        end
        else
        begin
            rd_idx = wrap_sum[AB-1:0];
        end
        if (rd_idx == '0)
        begin
            rd_prev = ffdl_pkg::LAST_ADDR;
        end
        else
        begin
            rd_prev = rd_idx - 1'b1;
        end
    end

    assign in_fire  = sample_ch.valid && sample_ch.ready;
    assign out_free = !out_valid_reg || result_ch.ready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffdl_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (bypass_reg)
                        state_next = ffdl_pkg::ST_RD_TAP;
                    else if (delay_whole_reg == '0)
                        state_next = ffdl_pkg::ST_FB_GO;
                    else
                        state_next = ffdl_pkg::ST_RD_A;
                end
            end
            ffdl_pkg::ST_RD_A:     state_next = ffdl_pkg::ST_RD_B;
            ffdl_pkg::ST_RD_B:     state_next = ffdl_pkg::ST_Y_GO;
            ffdl_pkg::ST_Y_GO:     state_next = ffdl_pkg::ST_Y_WAIT;
            ffdl_pkg::ST_Y_WAIT:
            begin
                if (mul_done)
                    state_next = ffdl_pkg::ST_FB_GO;
            end
            ffdl_pkg::ST_FB_GO:
            begin
                if (use_ext_fb_reg)
                    state_next = ffdl_pkg::ST_WRITE;
                else
                    state_next = ffdl_pkg::ST_FB_WAIT;
            end
            ffdl_pkg::ST_FB_WAIT:
            begin
                if (mul_done)
                    state_next = ffdl_pkg::ST_WRITE;
            end
            ffdl_pkg::ST_WRITE:    state_next = ffdl_pkg::ST_MIX_WAIT;
            ffdl_pkg::ST_MIX_WAIT:
            begin
                if (mul_done)
                    state_next = ffdl_pkg::ST_RD_TAP;
            end
            ffdl_pkg::ST_RD_TAP:   state_next = ffdl_pkg::ST_TAP_GO;
            ffdl_pkg::ST_TAP_GO:   state_next = ffdl_pkg::ST_TAP_WAIT;
            ffdl_pkg::ST_TAP_WAIT:
            begin
                if (mul_done)
                    state_next = ffdl_pkg::ST_OUT;
            end
            ffdl_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = ffdl_pkg::ST_IDLE;
            end
            default:               state_next = ffdl_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: store port and multiplier request
    always_comb
    begin
        raddr    = rd_idx;
        store_we = 1'b0;
        mul_req  = '0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ffdl_pkg::ST_RD_B:
            begin
                raddr = rd_prev;
            end
            ffdl_pkg::ST_Y_GO:
            begin
                // a + f * (b - a), rounded
                mul_req.start   = 1'b1;
                mul_req.shift16 = 1'b1;
                mul_a = {rd_val[SB-1], rd_val} - {a_reg[SB-1], a_reg};
                mul_b = delay_fraction_reg;
            end
            ffdl_pkg::ST_FB_GO:
            begin
                mul_req.start    = !use_ext_fb_reg;
                mul_req.b_signed = 1'b1;
                mul_a = {y_reg[SB-1], y_reg};
                mul_b = feedback_gain_reg;
            end
            ffdl_pkg::ST_WRITE:
            begin
                // x + m * (y - x), rounded
                store_we        = 1'b1;
                mul_req.start   = 1'b1;
                mul_req.shift16 = 1'b1;
                mul_a = {y_reg[SB-1], y_reg} - {x_reg[SB-1], x_reg};
                mul_b = mix_level_reg;
            end
            ffdl_pkg::ST_TAP_GO:
            begin
                mul_req.start    = 1'b1;
                mul_req.b_signed = 1'b1;
                mul_a = {rd_val[SB-1], rd_val};
                mul_b = feedback_gain_reg;
            end
            default:
            begin
                raddr = rd_idx;
            end
        endcase
    end

    ffdl_store u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (wp_reg),
        .wdata (stored_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    // entries never written since reset read as zero
    assign rd_val = rd_ok_reg ? rdata : '0;

    ffdl_smul u_smul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .a_op  (mul_a),
        .b_op  (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    assign x_wide   = {{(PB+1-SB){x_reg[SB-1]}}, x_reg};
    assign ext_wide = {{(PB+1-SB){ext_reg[SB-1]}}, ext_reg};
    assign res_wide = {mul_res[PB-1], mul_res};

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffdl_pkg::ST_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_ok_reg <= wrapped_reg || (raddr < wp_reg);
            if (state_reg == ffdl_pkg::ST_WRITE)
            begin
                if (wp_reg == ffdl_pkg::LAST_ADDR)
                begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
            if ((state_reg == ffdl_pkg::ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg     <= sample_ch.sample_in;
            ext_reg   <= sample_ch.external_feedback;
            y_reg     <= sample_ch.sample_in;
            mixed_reg <= sample_ch.sample_in;
        end
        if (state_reg == ffdl_pkg::ST_RD_B)
        begin
            a_reg <= rd_val;
        end
        if ((state_reg == ffdl_pkg::ST_Y_WAIT) && mul_done)
        begin
            y_reg <= a_reg + mul_res[SB-1:0];
        end
        if ((state_reg == ffdl_pkg::ST_FB_GO) && use_ext_fb_reg)
        begin
            stored_reg <= ffdl_pkg::sat_sample(x_wide + ext_wide);
        end
        if ((state_reg == ffdl_pkg::ST_FB_WAIT) && mul_done)
        begin
            stored_reg <= ffdl_pkg::sat_sample(x_wide + res_wide);
        end
        if ((state_reg == ffdl_pkg::ST_MIX_WAIT) && mul_done)
        begin
            mixed_reg <= ffdl_pkg::sat_sample(x_wide + res_wide);
        end
        if ((state_reg == ffdl_pkg::ST_TAP_WAIT) && mul_done)
        begin
            tap_reg <= ffdl_pkg::sat_sample(res_wide);
        end
        if ((state_reg == ffdl_pkg::ST_OUT) && out_free)
        begin
            out_sample_reg <= mixed_reg;
            out_fb_reg     <= tap_reg;
        end
    end

    assign sample_ch.ready        = (state_reg == ffdl_pkg::ST_IDLE) && !dmod_busy;
    assign result_ch.valid        = out_valid_reg;
    assign result_ch.sample_out   = out_sample_reg;
    assign result_ch.feedback_out = out_fb_reg;

endmodule

`default_nettype wire

### hw/rtl/ffdl_checker.sv
// port-level checks for the fractional feedback delay line, bound to the top level
// depends on ffdl_pkg for the register index names
`timescale 1ns / 1ps
`default_nettype none

module ffdl_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_ready,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_ready,
    input  wire logic [ffdl_pkg::SAMPLE_BITS-1:0]       sample_out,
    input  wire logic [ffdl_pkg::SAMPLE_BITS-1:0]       feedback_out,
    input  wire logic                                   cfg_we,
    input  wire logic [ffdl_pkg::CFG_INDEX_BITS-1:0]    cfg_index
);

    // a waiting result stays put until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(feedback_out))
        else $error("result changed or dropped while stalled");

    // one item at a time: an accepted item keeps the input closed next cycle
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item still in work");

    // a new whole delay must be reduced before the next item enters
    a_delay_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == ffdl_pkg::REG_DELAY_WHOLE) |=> !in_ready)
        else $error("item input open during delay reduction");

endmodule

bind fractional_feedback_delay_line ffdl_checker u_ffdl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_ch.valid),
    .in_ready     (sample_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .sample_out   (result_ch.sample_out),
    .feedback_out (result_ch.feedback_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index)
);

`default_nettype wire
